>>> src/rcdc_pkg.sv
package rcdc_pkg;

   localparam logic [63:0] RABIN_POLY = 64'hbfe6b8a5bf378d83;
   localparam int OUT_LEN_BITS = 25;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS = 32;
   localparam int WINDOW_RESET = 32;
   localparam int SKIP_KEEP = 256;
   localparam int SKIP_LIMIT = 512;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_BYTES = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_BLOCK = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_BLOCK = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MASK_BITS = 8'd3;

   typedef logic [7:0][63:0] basis_type;

   typedef struct packed {
      logic [7:0] window_bytes;
      logic [24:0] min_block;
      logic [24:0] max_block;
      logic [4:0] mask_bits;
   } cfg_type;

   typedef struct packed {
      logic [OUT_LEN_BITS-1:0] block_length;
      logic [63:0] block_fingerprint;
      logic stream_done;
   } result_type;

   // multiply by x modulo the polynomial
   function automatic logic [63:0] gf_xtime(input logic [63:0] v);
      logic [63:0] s;
      s = v << 1;
      if (s[63]) begin
         s = s ^ RABIN_POLY;
      end
      return s;
   endfunction

   function automatic logic [63:0] fold8(input logic [7:0] sel, input basis_type b);
      logic [63:0] acc;
      acc = '0;
      for (int k = 0; k < 8; k++) begin
         if (sel[k]) begin
            acc = acc ^ b[k];
         end
      end
      return acc;
   endfunction

   function automatic basis_type push_basis_init();
      basis_type t;
      logic [63:0] v;
      v = RABIN_POLY ^ 64'h8000000000000000;
      for (int k = 0; k < 8; k++) begin
         t[k] = v;
         v = gf_xtime(v);
      end
      t[0] = t[0] | 64'h8000000000000000;
      return t;
   endfunction

   localparam basis_type PUSH_BASIS = push_basis_init();

   // append one byte to a fingerprint
   function automatic logic [63:0] push_byte(input logic [63:0] p, input logic [7:0] m);
      return {p[55:0], m} ^ fold8(p[62:55], PUSH_BASIS);
   endfunction

endpackage

>>> src/rcdc_if.sv
interface rcdc_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic stream_last;
   modport source(output valid, output data_byte, output stream_last, input ready);
   modport sink(input valid, input data_byte, input stream_last, output ready);
endinterface

interface rcdc_rsp_if;
   logic valid;
   logic ready;
   logic [24:0] block_length;
   logic [63:0] block_fingerprint;
   logic stream_done;
   modport source(output valid, output block_length, output block_fingerprint,
                  output stream_done, input ready);
   modport sink(input valid, input block_length, input block_fingerprint,
                input stream_done, output ready);
endinterface

interface rcdc_csr_if;
   logic valid;
   logic ready;
   logic [7:0] index;
   logic [31:0] wdata;
   modport source(output valid, output index, output wdata, input ready);
   modport sink(input valid, input index, input wdata, output ready);
endinterface

>>> src/rabin_content_defined_chunker.sv
// Rolling-fingerprint chunker, one byte per cycle while req ready is high.
// A boundary item enters the result queue when the block's last byte is taken.
// Req is ready while the two-entry result queue has room and no rebuild runs.
// After reset and after every window_bytes write the pop basis is rebuilt
// over the window length (capped at MAX_WINDOW); req ready stays low till done.
// Reset is synchronous, active high; config returns to its reset values.
module rabin_content_defined_chunker #(
   parameter int MAX_WINDOW = 128,
   parameter int LENGTH_BITS = 25
) (
   input logic clock,
   input logic reset,
   rcdc_req_if.sink req_ch,
   rcdc_rsp_if.source rsp_ch,
   rcdc_csr_if.sink csr_ch
);
   import rcdc_pkg::*;

   localparam int PB = $clog2(MAX_WINDOW);
   localparam int WB = PB + 1;

   cfg_type cfg_ff;
   logic [WB-1:0] win;
   logic wr, start, busy, space, push;
   basis_type pop_basis;
   result_type result;

   assign csr_ch.ready = 1'b1;
   assign wr = csr_ch.valid;
   assign start = wr && (csr_ch.index == REG_WINDOW_BYTES);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_bytes <= 8'd32;
         cfg_ff.min_block <= 25'd2048;
         cfg_ff.max_block <= 25'd8192;
         cfg_ff.mask_bits <= 5'd12;
      end else if (wr) begin
         case (csr_ch.index)
            REG_WINDOW_BYTES: cfg_ff.window_bytes <= csr_ch.wdata[7:0];
            REG_MIN_BLOCK: cfg_ff.min_block <= csr_ch.wdata[24:0];
            REG_MAX_BLOCK: cfg_ff.max_block <= csr_ch.wdata[24:0];
            REG_MASK_BITS: cfg_ff.mask_bits <= csr_ch.wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   assign win = (cfg_ff.window_bytes == 8'd0) ? WB'(1) :
                (32'(cfg_ff.window_bytes) > 32'(MAX_WINDOW)) ? WB'(MAX_WINDOW) :
                WB'(cfg_ff.window_bytes);

   rcdc_span #(.WB(WB)) u_span (
      .clock(clock),
      .reset(reset),
      .start(start),
      .win(win),
      .busy(busy),
      .pop_basis(pop_basis)
   );

   rcdc_hash #(
      .MAX_WINDOW(MAX_WINDOW),
      .LENGTH_BITS(LENGTH_BITS),
      .PB(PB),
      .WB(WB)
   ) u_hash (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .cfg(cfg_ff),
      .win(win),
      .pop_basis(pop_basis),
      .hold(busy),
      .space(space),
      .push(push),
      .result(result)
   );

   rcdc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .din(result),
      .space(space),
      .rsp_ch(rsp_ch)
   );
endmodule

>>> src/rcdc_span.sv
module rcdc_span #(
   parameter int WB = 8
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [WB-1:0] win,
   output logic busy,
   output rcdc_pkg::basis_type pop_basis
);
   import rcdc_pkg::*;

   typedef enum logic [1:0] {ST_LOAD, ST_SPAN, ST_BASIS, ST_IDLE} state_type;

   state_type state_ff;
   logic [63:0] span_ff;
   logic [WB-1:0] cnt_ff;
   logic [2:0] k_ff;
   basis_type basis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else if (start) begin
         state_ff <= ST_LOAD;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               span_ff <= 64'd1;
               cnt_ff <= win - WB'(1);
               state_ff <= ST_SPAN;
            end
            ST_SPAN: begin
               if (cnt_ff == '0) begin
                  span_ff <= span_ff[63] ? (span_ff ^ RABIN_POLY) : span_ff;
                  k_ff <= 3'd0;
                  state_ff <= ST_BASIS;
               end else begin
                  span_ff <= push_byte(span_ff, 8'd0);
                  cnt_ff <= cnt_ff - WB'(1);
               end
            end
            ST_BASIS: begin
               basis_ff[k_ff] <= span_ff;
               span_ff <= gf_xtime(span_ff);
               k_ff <= k_ff + 3'd1;
               if (k_ff == 3'd7) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign pop_basis = basis_ff;
endmodule

>>> src/rcdc_hash.sv
module rcdc_hash #(
   parameter int MAX_WINDOW = 128,
   parameter int LENGTH_BITS = 25,
   parameter int PB = 7,
   parameter int WB = 8
) (
   input logic clock,
   input logic reset,
   rcdc_req_if.sink req_ch,
   input rcdc_pkg::cfg_type cfg,
   input logic [WB-1:0] win,
   input rcdc_pkg::basis_type pop_basis,
   input logic hold,
   input logic space,
   output logic push,
   output rcdc_pkg::result_type result
);
   import rcdc_pkg::*;

   localparam int CW = (LENGTH_BITS > 25) ? LENGTH_BITS : 25;

   logic [7:0] ring_mem [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] vld_ff;
   logic [7:0] old_ff;
   logic old_vld_ff;
   logic [PB-1:0] pos_ff, pos_in, wr_addr, rd_addr;
   logic [63:0] roll_ff, roll_in, roll_h, roll_n, r1;
   logic [LENGTH_BITS-1:0] len_ff, len_in, len_n;
   logic [24:0] skip;
   logic [31:0] mask;
   logic acc, hash_en, bnd, clr, coll;

   function automatic logic [PB-1:0] nxt(input logic [PB-1:0] p, input logic [WB-1:0] w);
      logic [WB-1:0] q;
      q = WB'(p) + WB'(1);
      return (q >= w) ? '0 : PB'(q);
   endfunction

   assign req_ch.ready = !hold && space;
   assign acc = req_ch.valid && req_ch.ready;

   assign skip = (cfg.min_block > 25'(SKIP_LIMIT)) ? (cfg.min_block - 25'(SKIP_KEEP)) : '0;
   assign hash_en = acc && (CW'(len_ff) >= CW'(skip));
   assign wr_addr = nxt(pos_ff, win);

   assign r1 = roll_ff ^ fold8(old_vld_ff ? old_ff : 8'd0, pop_basis);
   assign roll_h = push_byte(r1, req_ch.data_byte);
   assign roll_n = hash_en ? roll_h : roll_ff;
   assign len_n = len_ff + LENGTH_BITS'(1);
   assign mask = 32'((33'd1 << cfg.mask_bits) - 33'd1);

   assign bnd = (CW'(len_n) >= CW'(cfg.max_block)) || (len_n == '1) ||
                ((CW'(len_n) >= CW'(cfg.min_block)) && ((roll_n[31:0] & mask) == mask));
   assign push = acc && (bnd || req_ch.stream_last);
   assign clr = acc && req_ch.stream_last;

   assign result.block_length = OUT_LEN_BITS'(len_n);
   assign result.block_fingerprint = roll_n;
   assign result.stream_done = req_ch.stream_last;

   always_comb begin
      pos_in = pos_ff;
      roll_in = roll_ff;
      len_in = len_ff;
      if (acc) begin
         if (clr) begin
            pos_in = PB'(win - WB'(1));
            roll_in = '0;
            len_in = '0;
         end else begin
            if (hash_en) begin
               pos_in = wr_addr;
            end
            roll_in = roll_n;
            len_in = bnd ? '0 : len_n;
         end
      end
   end

   assign rd_addr = nxt(pos_in, win);
   assign coll = hash_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= PB'(WINDOW_RESET - 1);
         roll_ff <= '0;
         len_ff <= '0;
         vld_ff <= '0;
         old_vld_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         roll_ff <= roll_in;
         len_ff <= len_in;
         if (clr) begin
            vld_ff <= '0;
            old_vld_ff <= 1'b0;
         end else begin
            if (hash_en) begin
               vld_ff[wr_addr] <= 1'b1;
            end
            old_vld_ff <= coll ? 1'b1 : vld_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hash_en) begin
         ring_mem[wr_addr] <= req_ch.data_byte;
      end
      old_ff <= coll ? req_ch.data_byte : ring_mem[rd_addr];
   end
endmodule

>>> src/rcdc_queue.sv
module rcdc_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input rcdc_pkg::result_type din,
   output logic space,
   rcdc_rsp_if.source rsp_ch
);
   import rcdc_pkg::*;

   result_type ent_ff [2];
   logic wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic pop;

   assign space = (cnt_ff != 2'd2);
   assign rsp_ch.valid = (cnt_ff != 2'd0);
   assign pop = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.block_length = ent_ff[rd_ff].block_length;
   assign rsp_ch.block_fingerprint = ent_ff[rd_ff].block_fingerprint;
   assign rsp_ch.stream_done = ent_ff[rd_ff].stream_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= din;
      end
   end
endmodule

>>> verif/tb_rabin_content_defined_chunker.sv
`timescale 1ns / 1ps

module tb_rabin_content_defined_chunker;
   import rcdc_pkg::*;

   localparam int WIN_CAP = 128;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [24:0] LEN_FULL = 25'h1ffffff;

   logic clock = 1'b0;
   logic reset;

   rcdc_req_if req_bus();
   rcdc_rsp_if rsp_bus();
   rcdc_csr_if csr_bus();

   rabin_content_defined_chunker uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_ch(csr_bus)
   );

   always #5 clock = ~clock;

   // chunker state as predicted
   logic [63:0] fp_push_tab [256];
   logic [63:0] fp_pop_tab [256];
   logic [7:0] win_ring [WIN_CAP];
   int unsigned ring_pos;
   logic [63:0] fp_value;
   logic [24:0] blk_len;
   cfg_type cfg;

   result_type expected_blocks[$];
   int error_count = 0;
   int cycle_count = 0;
   bit idling = 1'b1;
   int hold_cycles = 0;
   int stall_left = 0;

   function automatic logic [63:0] gf_mul_mod(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] acc;
      acc = '0;
      if (y[63]) y = y ^ RABIN_POLY;
      for (int b = 63; b >= 0; b--) begin
         acc = acc << 1;
         if (acc[63]) acc = acc ^ RABIN_POLY;
         if (x[b]) acc = acc ^ y;
      end
      return acc;
   endfunction

   function automatic logic [63:0] fp_append(input logic [63:0] p, input logic [7:0] m);
      return {p[55:0], m} ^ fp_push_tab[p[62:55]];
   endfunction

   function automatic int unsigned window_len();
      int unsigned w;
      w = cfg.window_bytes;
      if (w < 1) w = 1;
      if (w > WIN_CAP) w = WIN_CAP;
      return w;
   endfunction

   function automatic void build_pop_tab();
      logic [63:0] span;
      span = 64'd1;
      for (int i = 1; i < window_len(); i++) span = fp_append(span, 8'h00);
      for (int i = 0; i < 256; i++) fp_pop_tab[i] = gf_mul_mod(64'(i), span);
   endfunction

   function automatic void clear_stream();
      foreach (win_ring[i]) win_ring[i] = 8'h00;
      ring_pos = window_len() - 1;
      fp_value = '0;
      blk_len = '0;
   endfunction

   function automatic void model_reset();
      logic [63:0] top;
      top = 64'h8000000000000000 ^ RABIN_POLY;
      for (int i = 0; i < 256; i++)
         fp_push_tab[i] = gf_mul_mod(64'(i), top) | (64'(i & 1) << 63);
      cfg.window_bytes = 8'd32;
      cfg.min_block = 25'd2048;
      cfg.max_block = 25'd8192;
      cfg.mask_bits = 5'd12;
      build_pop_tab();
      clear_stream();
   endfunction

   function automatic void chunk_predict(input logic [7:0] m, input logic last);
      logic [24:0] skip;
      logic [63:0] mask;
      logic [7:0] old;
      bit boundary;
      result_type r;
      skip = (cfg.min_block > SKIP_LIMIT) ? cfg.min_block - 25'(SKIP_KEEP) : '0;
      mask = (64'd1 << cfg.mask_bits) - 64'd1;
      if (blk_len >= skip) begin
         ring_pos++;
         if (ring_pos >= window_len()) ring_pos = 0;
         old = win_ring[ring_pos % WIN_CAP];
         win_ring[ring_pos % WIN_CAP] = m;
         fp_value = fp_append(fp_value ^ fp_pop_tab[old], m);
      end
      blk_len = blk_len + 25'd1;
      boundary = (blk_len >= cfg.max_block) || (blk_len == LEN_FULL) ||
                 (blk_len >= cfg.min_block && (fp_value & mask) == mask);
      if (!boundary && !last) return;
      r.block_length = blk_len;
      r.block_fingerprint = fp_value;
      r.stream_done = last;
      expected_blocks.push_back(r);
      if (last) clear_stream();
      else blk_len = '0;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d blocks outstanding", expected_blocks.size());
         $display("tb_rabin_content_defined_chunker: done, errors");
         $finish;
      end
   end

   // receiver with random stalls and an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles--;
      end else if (!idling) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(1, 19) - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch("unexpected block", 64'(rsp_bus.block_length), 64'd0);
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_bus.block_length !== want.block_length)
               report_mismatch("block_length", 64'(rsp_bus.block_length),
                               64'(want.block_length));
            if (rsp_bus.block_fingerprint !== want.block_fingerprint)
               report_mismatch("block_fingerprint", rsp_bus.block_fingerprint,
                               want.block_fingerprint);
            if (rsp_bus.stream_done !== want.stream_done)
               report_mismatch("stream_done", 64'(rsp_bus.stream_done),
                               64'(want.stream_done));
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (idling && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.stream_last <= last;
      do @(posedge clock); while (!req_bus.ready);
      chunk_predict(b, last);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         REG_WINDOW_BYTES: begin
            cfg.window_bytes = value[7:0];
            build_pop_tab();
         end
         REG_MIN_BLOCK: cfg.min_block = value[24:0];
         REG_MAX_BLOCK: cfg.max_block = value[24:0];
         REG_MASK_BITS: cfg.mask_bits = value[4:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input int w, input int mn, input int mx, input int mk);
      write_reg(REG_WINDOW_BYTES, 32'(w));
      write_reg(REG_MIN_BLOCK, 32'(mn));
      write_reg(REG_MAX_BLOCK, 32'(mx));
      write_reg(REG_MASK_BITS, 32'(mk));
   endtask

   task automatic send_random(input int n, input int last_odds);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, last_odds) == 0);
   endtask

   task automatic test_reset_defaults();
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7f, 1'b1);
      send_byte(8'h55, 1'b1);
   endtask

   task automatic test_every_byte_boundary();
      set_config(0, 0, 0, 0);
      send_byte(8'haa, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
   endtask

   task automatic test_zero_mask_wide_window();
      set_config(255, 3, 10, 0);
      for (int i = 0; i < 6; i++) send_byte(8'(i * 51), i == 5);
      set_config(200, 16777216, 16777216, 31);
      send_random(4, 1000);
      send_byte(8'hc3, 1'b1);
   endtask

   task automatic test_skip_region();
      set_config(128, 513, 280, 31);
      send_random(283, 100000);
      send_byte(8'h3c, 1'b1);
   endtask

   task automatic test_window_change_midstream();
      set_config(128, 8, 40, 4);
      send_random(20, 100000);
      write_reg(REG_WINDOW_BYTES, 32'd32);
      send_random(20, 100000);
      write_reg(REG_WINDOW_BYTES, 32'd1);
      send_random(8, 100000);
      send_byte(8'h99, 1'b1);
   endtask

   task automatic test_backpressure();
      set_config(32, 1, 1, 0);
      hold_cycles = 80;
      send_random(30, 100000);
      wait_drained();
   endtask

   task automatic test_random_streams(input int rounds, input int per_round);
      int mn;
      int w;
      for (int r = 0; r < rounds; r++) begin
         mn = $urandom_range(1, 40);
         case ($urandom_range(0, 5))
            0: w = $urandom_range(1, 31);
            1: w = $urandom_range(129, 255);
            2: w = 128;
            default: w = $urandom_range(32, 128);
         endcase
         if ($urandom_range(0, 4) == 0)
            set_config(w, mn, $urandom_range(0, mn), $urandom_range(0, 31));
         else
            set_config(w, mn, mn + $urandom_range(0, 40), $urandom_range(0, 6));
         send_random(per_round, 30);
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.stream_last <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.wdata <= '0;
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_every_byte_boundary();
      test_zero_mask_wide_window();
      test_skip_region();
      test_window_change_midstream();
      test_backpressure();
      test_random_streams(3, 12);
      wait_drained();
      idling = 1'b0;
      test_random_streams(2, 12);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_rabin_content_defined_chunker: done, clean");
      end else begin
         $display("tb_rabin_content_defined_chunker: done, errors");
      end
      $finish;
   end

endmodule
